@@ rtl/ajbr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ajbr_pkg;

    // Ring geometry
    localparam int RING_AW    = 14;
    localparam int RING_DEPTH = 1 << RING_AW;
    localparam int FILL_W     = 14;

    // Rate control and limits
    localparam logic [16:0] RATE_ONE     = 17'd65536;
    localparam logic [10:0] CORR_LIMIT   = 11'd1311;
    localparam logic [16:0] RATE_MIN     = RATE_ONE - 17'(CORR_LIMIT);
    localparam logic [16:0] RATE_MAX     = RATE_ONE + 17'(CORR_LIMIT);
    localparam logic [31:0] GAP_LIMIT    = 32'd1000;
    localparam logic [11:0] TARGET_RESET = 12'd1440;
    localparam logic [3:0]  DIV_TOP      = 4'd11;

    // Item kinds
    localparam logic [1:0] FUNC_SEQ = 2'd0;
    localparam logic [1:0] FUNC_WR  = 2'd1;
    localparam logic [1:0] FUNC_RD  = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [31:0]        seq_number;
        logic signed [15:0] sample_in;
        logic               first_in_block;
    } ajbr_in_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               underrun;
        logic [13:0]        fill_level;
        logic [16:0]        rate_q16;
        logic [31:0]        lost_total;
        logic [31:0]        underrun_total;
        logic [14:0]        peak_abs;
    } ajbr_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_FIN
    } ajbr_state_t;

endpackage

`default_nettype wire

@@ rtl/adaptive_jitter_buffer_resampler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload                Notes
// in        in_valid / in_ready   ajbr_in_t in_data      one item at a time
// out       out_valid / out_ready ajbr_out_t out_data    one result per item
// cfg       cfg_we                cfg_data[11:0]         target_fill, no wait
//
// Sequence, write and unused items go through accept and finish. A read
// adds two ring reads on the single memory read port and one multiply
// before the finish; a read that underruns skips the reads and multiply. A
// first read of a block with a nonzero target runs the bit-serial rate divider.
// After reset a clearing pass zeroes the ring, one entry a cycle, with
// in_ready low. The finish step stalls while the output register still
// holds an untaken result.

module adaptive_jitter_buffer_resampler (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ajbr_pkg::ajbr_in_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ajbr_pkg::ajbr_out_t     out_data,
    input  wire logic               cfg_we,
    input  wire logic [11:0]        cfg_data
);
    import ajbr_pkg::*;

    // Control state
    ajbr_state_t          state_reg, state_next;
    logic [11:0]          target_reg;
    logic [RING_AW-1:0]   wp_reg, wp_next;
    logic [RING_AW-1:0]   rp_reg, rp_next;
    logic [RING_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [15:0]          phase_reg, phase_next;
    logic [16:0]          rate_reg, rate_next;
    logic [31:0]          prev_seq_reg, prev_seq_next;
    logic                 seq_seen_reg, seq_seen_next;
    logic [31:0]          lost_reg, lost_next;
    logic [31:0]          urun_cnt_reg, urun_cnt_next;
    logic [14:0]          peak_reg, peak_next;
    logic                 out_valid_reg, out_valid_next;
    logic [3:0]           div_cnt_reg, div_cnt_next;

    // Payload state
    ajbr_in_t             item_reg, item_next;
    ajbr_out_t            out_reg, out_next;
    logic [31:0]          div_rem_reg, div_rem_next;
    logic [29:0]          div_dsh_reg, div_dsh_next;
    logic [10:0]          div_q_reg, div_q_next;
    logic                 div_ovf_reg, div_ovf_next;
    logic                 div_neg_reg, div_neg_next;
    logic signed [15:0]   a_reg, a_next;
    logic signed [33:0]   prod_reg, prod_next;

    // Ring memory
    logic [15:0]          ring_mem [RING_DEPTH];
    logic [15:0]          mem_rdata_reg;
    logic                 mem_we;
    logic [RING_AW-1:0]   mem_waddr;
    logic [15:0]          mem_wdata;
    logic [RING_AW-1:0]   mem_raddr;

    // Shared helpers
    logic [RING_AW-1:0]   fill_cur;
    logic                 fill_low;
    logic [13:0]          err_mag;
    logic [17:0]          den;
    logic [31:0]          div_num;
    logic                 div_take;
    logic [10:0]          div_q_full;
    logic [10:0]          corr;
    logic signed [15:0]   b_val;
    logic signed [16:0]   diff;
    logic signed [34:0]   interp_sum;
    logic signed [18:0]   q_trunc;
    logic signed [15:0]   interp_out;
    logic [14:0]          interp_mag;
    logic [14:0]          peak_base;
    logic [17:0]          phase_sum;
    logic [31:0]          gap;
    logic [32:0]          lost_sum;
    logic [32:0]          urun_sum;
    logic                 commit;
    logic                 accept;
    logic [RING_AW-1:0]   fill_out;

    assign fill_cur = wp_reg - rp_reg;
    assign fill_low = (fill_cur <= RING_AW'(1));
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // Divider operands: round(|err| * 65536 / (50 * target))
    assign err_mag = (fill_cur >= RING_AW'(in_data.first_in_block ? target_reg : 12'd0))
                     ? 14'(fill_cur - RING_AW'(target_reg))
                     : 14'(RING_AW'(target_reg) - fill_cur);
    assign den     = (18'(target_reg) << 5) + (18'(target_reg) << 4) + (18'(target_reg) << 1);
    assign div_num = ({err_mag, 18'b0} >> 1) + 32'(den);

    // Quotient including the bit decided this cycle
    assign div_take   = ({2'b0, div_dsh_reg} <= div_rem_reg);
    assign div_q_full = {div_q_reg[9:0], div_take};
    assign corr       = (div_ovf_reg || (div_q_full > CORR_LIMIT)) ? CORR_LIMIT : div_q_full;

    // Interpolation: a + (b - a) * f, truncated toward zero
    assign b_val      = signed'(mem_rdata_reg);
    assign diff       = 17'(b_val) - 17'(a_reg);
    assign interp_sum = {{3{a_reg[15]}}, a_reg, 16'b0} + {prod_reg[33], prod_reg};
    assign q_trunc    = interp_sum[34:16]
                        + 19'((interp_sum[34] && (interp_sum[15:0] != 16'd0)) ? 1 : 0);
    assign interp_out = (q_trunc > 19'sd32767)  ? 16'sh7FFF :
                        (q_trunc < -19'sd32768) ? 16'sh8000 : 16'(q_trunc);
    assign interp_mag = (interp_out == 16'sh8000) ? 15'h7FFF :
                        interp_out[15] ? 15'(-interp_out) : interp_out[14:0];
    assign peak_base  = item_reg.first_in_block ? 15'd0 : peak_reg;
    assign phase_sum  = {2'b0, phase_reg} + {1'b0, rate_reg};

    assign gap      = item_reg.seq_number - prev_seq_reg - 32'd1;
    assign lost_sum = {1'b0, lost_reg} + {1'b0, gap};
    assign urun_sum = {1'b0, urun_cnt_reg} + 33'd1;

    assign fill_out = wp_next - rp_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Hold state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            target_reg    <= TARGET_RESET;
            wp_reg        <= RING_AW'(TARGET_RESET % RING_DEPTH);
            rp_reg        <= '0;
            clr_cnt_reg   <= '0;
            phase_reg     <= '0;
            rate_reg      <= RATE_ONE;
            prev_seq_reg  <= '0;
            seq_seen_reg  <= 1'b0;
            lost_reg      <= '0;
            urun_cnt_reg  <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                target_reg <= cfg_data;
            end
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            clr_cnt_reg   <= clr_cnt_next;
            phase_reg     <= phase_next;
            rate_reg      <= rate_next;
            prev_seq_reg  <= prev_seq_next;
            seq_seen_reg  <= seq_seen_next;
            lost_reg      <= lost_next;
            urun_cnt_reg  <= urun_cnt_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        out_reg     <= out_next;
        div_rem_reg <= div_rem_next;
        div_dsh_reg <= div_dsh_next;
        div_q_reg   <= div_q_next;
        div_ovf_reg <= div_ovf_next;
        div_neg_reg <= div_neg_next;
        a_reg       <= a_next;
        prod_reg    <= prod_next;
    end

    // Ring memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= ring_mem[mem_raddr];
    end

    // Sequence the item and compute next state
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        clr_cnt_next   = clr_cnt_reg;
        phase_next     = phase_reg;
        rate_next      = rate_reg;
        prev_seq_next  = prev_seq_reg;
        seq_seen_next  = seq_seen_reg;
        lost_next      = lost_reg;
        urun_cnt_next  = urun_cnt_reg;
        peak_next      = peak_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_cnt_next   = div_cnt_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        div_rem_next   = div_rem_reg;
        div_dsh_next   = div_dsh_reg;
        div_q_next     = div_q_reg;
        div_ovf_next   = div_ovf_reg;
        div_neg_next   = div_neg_reg;
        a_next         = a_reg;
        prod_next      = prod_reg;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = item_reg.sample_in;
        mem_raddr      = rp_reg;

        case (state_reg)
            // Zero the ring after reset
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + RING_AW'(1);
                if (clr_cnt_reg == {RING_AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end

            // Take an item, load the divider and run it if the rate is due
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next    = in_data;
                    div_rem_next = div_num;
                    div_dsh_next = {den, 1'b0, 11'b0};
                    div_q_next   = '0;
                    div_ovf_next = 1'b0;
                    div_neg_next = (fill_cur < RING_AW'(target_reg));
                    div_cnt_next = DIV_TOP;
                    if (in_data.func == FUNC_RD)
                    begin
                        if (in_data.first_in_block && (target_reg != 12'd0))
                        begin
                            state_next = ST_DIV;
                        end
                        else if (fill_low)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_RD_A;
                        end
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            // One quotient bit a cycle, top step checks for clamp
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_TOP)
                begin
                    div_ovf_next = div_take;
                end
                else if (div_take)
                begin
                    div_rem_next = div_rem_reg - {2'b0, div_dsh_reg};
                    div_q_next   = div_q_full;
                end
                else
                begin
                    div_q_next = div_q_full;
                end
                div_dsh_next = div_dsh_reg >> 1;
                div_cnt_next = div_cnt_reg - 4'd1;
                if (div_cnt_reg == 4'd0)
                begin
                    rate_next  = div_neg_reg ? (RATE_ONE - 17'(corr)) : (RATE_ONE + 17'(corr));
                    state_next = fill_low ? ST_FIN : ST_RD_A;
                end
            end

            // Fetch the older sample
            ST_RD_A:
            begin
                mem_raddr  = rp_reg;
                state_next = ST_RD_B;
            end

            // Capture it and fetch the next one
            ST_RD_B:
            begin
                mem_raddr  = rp_reg + RING_AW'(1);
                a_next     = signed'(mem_rdata_reg);
                state_next = ST_MUL;
            end

            // Weight the difference by the phase
            ST_MUL:
            begin
                prod_next  = diff * $signed({1'b0, phase_reg});
                state_next = ST_FIN;
            end

            // Apply the item and load the output register
            ST_FIN:
            begin
                if (commit)
                begin
                    out_next.sample_out = '0;
                    out_next.underrun   = 1'b0;
                    case (item_reg.func)
                        FUNC_SEQ:
                        begin
                            if (seq_seen_reg && (gap != 32'd0) && (gap < GAP_LIMIT))
                            begin
                                lost_next = lost_sum[32] ? 32'hFFFF_FFFF : lost_sum[31:0];
                            end
                            prev_seq_next = item_reg.seq_number;
                            seq_seen_next = 1'b1;
                        end
                        FUNC_WR:
                        begin
                            if (fill_cur == {RING_AW{1'b1}})
                            begin
                                rp_next = rp_reg + RING_AW'(1);
                            end
                            mem_we  = 1'b1;
                            wp_next = wp_reg + RING_AW'(1);
                        end
                        FUNC_RD:
                        begin
                            peak_next = peak_base;
                            if (fill_low)
                            begin
                                out_next.underrun = 1'b1;
                                urun_cnt_next     = urun_sum[32] ? 32'hFFFF_FFFF
                                                                 : urun_sum[31:0];
                            end
                            else
                            begin
                                out_next.sample_out = interp_out;
                                phase_next          = phase_sum[15:0];
                                rp_next             = rp_reg + RING_AW'(phase_sum[17:16]);
                                if (interp_mag > peak_base)
                                begin
                                    peak_next = interp_mag;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    out_next.fill_level     = FILL_W'(fill_out);
                    out_next.rate_q16       = rate_next;
                    out_next.lost_total     = lost_next;
                    out_next.underrun_total = urun_cnt_next;
                    out_next.peak_abs       = peak_next;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks on internal behavior
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("item taken during ring clear");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in work");

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rate_reg >= RATE_MIN) && (rate_reg <= RATE_MAX))
        else $error("playback rate outside clamp");

    a_urun_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.underrun) |-> (out_data.sample_out == 16'sd0))
        else $error("underrun result is not silent");

endmodule

`default_nettype wire

@@ verif/ajbr_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the config port of the jitter buffer, keeps its
// own copy of the ring, pointers, rate and counters, and checks every result
// transfer against the oldest predicted result.
module ajbr_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire ajbr_pkg::ajbr_in_t  in_data,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire ajbr_pkg::ajbr_out_t out_data,
    input  wire logic                cfg_we,
    input  wire logic [11:0]         cfg_data,
    output int                       fail_count,
    output int                       results_due,
    output logic [13:0]              predicted_fill
);
    import ajbr_pkg::*;

    localparam int PCM_MAX = 32767;
    localparam int PCM_MIN = -32768;

    // Buffer state as the block should hold it
    logic signed [15:0] pcm_ring [RING_DEPTH];
    logic [13:0]        wr_ptr;
    logic [13:0]        rd_ptr;
    int unsigned        phase;
    logic [16:0]        play_rate;
    logic [31:0]        last_seq;
    logic               seq_valid;
    logic [31:0]        lost_cnt;
    logic [31:0]        underrun_cnt;
    logic [14:0]        peak;
    logic [11:0]        target;

    ajbr_out_t          pending_results[$];
    int                 mismatches;

    // Playback rate from the fill error, rounded half away from zero and clamped
    function automatic logic [16:0] rate_for(logic [13:0] fill, logic [11:0] tgt);
        longint err;
        longint num;
        longint den;
        longint mag;
        longint corr;
        err  = longint'(fill) - longint'(tgt);
        num  = err * longint'(RATE_ONE);
        den  = 50 * longint'(tgt);
        mag  = (num < 0) ? -num : num;
        corr = (2 * mag + den) / (2 * den);
        if (corr > longint'(CORR_LIMIT))
            corr = longint'(CORR_LIMIT);
        if (num < 0)
            corr = -corr;
        return 17'(longint'(RATE_ONE) + corr);
    endfunction

    // Linear interpolation between two samples, truncated toward zero
    function automatic logic signed [15:0] lerp(logic signed [15:0] a, logic signed [15:0] b,
                                                int unsigned frac);
        longint acc;
        longint q;
        acc = longint'(a) * (longint'(RATE_ONE) - longint'(frac)) + longint'(b) * longint'(frac);
        q   = (acc < 0) ? -((-acc) / longint'(RATE_ONE)) : acc / longint'(RATE_ONE);
        if (q > PCM_MAX)
            q = PCM_MAX;
        if (q < PCM_MIN)
            q = PCM_MIN;
        return 16'(q);
    endfunction

    // Apply one item to the buffer state and return the result it should produce
    function automatic ajbr_out_t resample_step(ajbr_in_t it);
        ajbr_out_t          res;
        logic [31:0]        gap;
        logic [13:0]        fill;
        logic [13:0]        nxt;
        logic signed [15:0] smp;
        int                 mag;
        res = '0;
        case (it.func)
            FUNC_SEQ:
            begin
                if (seq_valid)
                begin
                    gap = it.seq_number - last_seq - 32'd1;
                    if (gap >= 32'd1 && gap < GAP_LIMIT)
                        lost_cnt = (lost_cnt > ~gap) ? '1 : lost_cnt + gap;
                end
                last_seq  = it.seq_number;
                seq_valid = 1'b1;
            end
            FUNC_WR:
            begin
                // Drop the oldest sample when the ring is full
                if (14'(wr_ptr - rd_ptr) == 14'(RING_DEPTH - 1))
                    rd_ptr = rd_ptr + 14'd1;
                pcm_ring[wr_ptr] = it.sample_in;
                wr_ptr = wr_ptr + 14'd1;
            end
            FUNC_RD:
            begin
                fill = wr_ptr - rd_ptr;
                if (it.first_in_block)
                begin
                    if (target != '0)
                        play_rate = rate_for(fill, target);
                    peak = '0;
                end
                if (fill <= 14'd1)
                begin
                    res.underrun = 1'b1;
                    if (underrun_cnt != '1)
                        underrun_cnt = underrun_cnt + 32'd1;
                end
                else
                begin
                    nxt = rd_ptr + 14'd1;
                    smp = lerp(pcm_ring[rd_ptr], pcm_ring[nxt], phase);
                    res.sample_out = smp;
                    // Advance the read pointer by each whole unit of phase
                    phase = phase + play_rate;
                    while (phase >= RATE_ONE)
                    begin
                        phase  = phase - RATE_ONE;
                        rd_ptr = rd_ptr + 14'd1;
                    end
                    mag = (smp < 0) ? -int'(smp) : int'(smp);
                    if (mag > PCM_MAX)
                        mag = PCM_MAX;
                    if (mag > int'(peak))
                        peak = 15'(mag);
                end
            end
            default:
            begin
            end
        endcase
        res.fill_level     = wr_ptr - rd_ptr;
        res.rate_q16       = play_rate;
        res.lost_total     = lost_cnt;
        res.underrun_total = underrun_cnt;
        res.peak_abs       = peak;
        return res;
    endfunction

    function automatic string show(ajbr_out_t r);
        return $sformatf("sample=%0d underrun=%0b fill=%0d rate=%0d lost=%0d underruns=%0d peak=%0d",
                         r.sample_out, r.underrun, r.fill_level, r.rate_q16, r.lost_total,
                         r.underrun_total, r.peak_abs);
    endfunction

    // Track config writes, predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        ajbr_out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
                pcm_ring[i] = '0;
            target       = TARGET_RESET;
            wr_ptr       = 14'(TARGET_RESET);
            rd_ptr       = '0;
            phase        = 0;
            play_rate    = RATE_ONE;
            last_seq     = '0;
            seq_valid    = 1'b0;
            lost_cnt     = '0;
            underrun_cnt = '0;
            peak         = '0;
            pending_results.delete();
            mismatches   = 0;
            fail_count     <= 0;
            results_due    <= 0;
            predicted_fill <= 14'(TARGET_RESET);
        end
        else
        begin
            if (cfg_we)
                target = cfg_data;

            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result: %s", $realtime, show(out_data));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.sample_out !== want.sample_out ||
                        out_data.underrun !== want.underrun ||
                        out_data.fill_level !== want.fill_level ||
                        out_data.rate_q16 !== want.rate_q16 ||
                        out_data.lost_total !== want.lost_total ||
                        out_data.underrun_total !== want.underrun_total ||
                        out_data.peak_abs !== want.peak_abs)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(out_data));
                        end
                    end
                end
            end

            if (in_valid && in_ready)
                pending_results.push_back(resample_step(in_data));

            fail_count     <= mismatches;
            results_due    <= pending_results.size();
            predicted_fill <= wr_ptr - rd_ptr;
        end
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import ajbr_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    ajbr_in_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    ajbr_out_t   out_data;
    logic        cfg_we = 1'b0;
    logic [11:0] cfg_data = '0;

    int          fail_count;
    int          results_due;
    logic [13:0] predicted_fill;

    logic [31:0] seq_cursor = '0;
    bit          steady_send = 1'b0;

    adaptive_jitter_buffer_resampler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    ajbr_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .results_due    (results_due),
        .predicted_fill (predicted_fill)
    );

    always #4 clk = ~clk;

    // Sender gap: mostly none or short, a few long
    function automatic int unsigned send_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver stall: mostly short, a few long
    function automatic int unsigned stall_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Item of the given kind; fields the kind ignores carry random bits
    function automatic ajbr_in_t blank_item(logic [1:0] kind);
        ajbr_in_t it;
        it.func           = kind;
        it.seq_number     = $urandom;
        it.sample_in      = 16'($urandom);
        it.first_in_block = 1'($urandom);
        return it;
    endfunction

    function automatic ajbr_in_t seq_item(logic [31:0] num);
        ajbr_in_t it;
        it = blank_item(FUNC_SEQ);
        it.seq_number = num;
        return it;
    endfunction

    function automatic ajbr_in_t write_item(logic [15:0] smp);
        ajbr_in_t it;
        it = blank_item(FUNC_WR);
        it.sample_in = smp;
        return it;
    endfunction

    function automatic ajbr_in_t read_item(bit first);
        ajbr_in_t it;
        it = blank_item(FUNC_RD);
        it.first_in_block = first;
        return it;
    endfunction

    // Packet numbering: mostly in order, some losses, a few jumps and repeats
    function automatic logic [31:0] next_seq();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            seq_cursor = seq_cursor + 32'd1;
        else if (r < 88)
            seq_cursor = seq_cursor + $urandom_range(2, 1000);
        else if (r < 93)
            seq_cursor = seq_cursor + $urandom_range(1001, 1000000);
        else if (r >= 96)
            seq_cursor = $urandom;
        return seq_cursor;
    endfunction

    function automatic ajbr_in_t random_item(int unsigned write_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 7)
            return seq_item(next_seq());
        if (r < 9)
            return blank_item(FUNC_UNUSED);
        if (r < 9 + write_pct)
            return write_item(pick_sample());
        return read_item($urandom_range(0, 7) == 0);
    endfunction

    task automatic hold_input(input int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Present one item and hold it until the transfer
    task automatic send_item(input ajbr_in_t item);
        int unsigned gap;
        gap = steady_send ? 0 : send_gap();
        if (gap != 0)
            hold_input(gap);
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and wait for every predicted result to come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [11:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_random(input int count, input int unsigned write_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 79) == 0)
                steady_send = ~steady_send;
            send_item(random_item(write_pct));
        end
        steady_send = 1'b0;
    endtask

    // Receiver: stretches of steady ready, otherwise short runs between stalls
    initial
    begin
        forever
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ready <= 1'b0;
                repeat (stall_len()) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [11:0] phase_target [5];
        int unsigned phase_pct [5];
        phase_target = '{12'd0, 12'd4095, 12'd1, 12'd0, 12'd1440};
        phase_pct    = '{50, 55, 50, 58, 50};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Packet numbering: first number, in order, gaps at both limits, wrap, repeat
        send_item(seq_item(32'd0));
        send_item(seq_item(32'd1));
        send_item(seq_item(32'd3));
        send_item(seq_item(32'd1003));
        send_item(seq_item(32'd2004));
        send_item(seq_item(32'hFFFF_FFFF));
        send_item(seq_item(32'd0));
        send_item(seq_item(32'd0));
        send_item(seq_item(32'd5));
        seq_cursor = 32'd5;

        // Sample extremes into the ring behind the silence prefill
        send_item(write_item(16'h7FFF));
        send_item(write_item(16'h8000));
        send_item(write_item(16'h0000));
        send_item(write_item(16'hFFFF));
        send_item(write_item(16'h5555));
        send_item(write_item(16'hAAAA));

        // Reads with and without a block start, then the unused kind
        send_item(read_item(1'b1));
        send_item(read_item(1'b0));
        send_item(read_item(1'b0));
        send_item(read_item(1'b1));
        send_item(blank_item(FUNC_UNUSED));
        send_item(read_item(1'b0));

        // Drain against the smallest nonzero target until reads run dry
        wait_idle();
        cfg_write(12'd1);
        while (predicted_fill > 14'd2)
            send_item(read_item($urandom_range(0, 5) == 0));
        repeat (6) send_item(read_item($urandom_range(0, 1) == 1));

        // Random traffic under several targets, zero and the extremes among them
        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            cfg_write(p == 3 ? 12'($urandom_range(2, 4094)) : phase_target[p]);
            run_random(30, phase_pct[p]);
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ajbr_pkg.sv
rtl/adaptive_jitter_buffer_resampler.sv
verif/ajbr_checker.sv
verif/testbench.sv
